/* hdl/v29tx_pkg.sv */
// Shared types and constants of the V.29-style 8-phase DPSK transmitter.
// Item structs, controller/datapath command and status, constellation and pulse tables.
// No dependencies.
package v29tx_pkg;

  localparam int SAMPLE_W  = 16;
  localparam int SPS       = 10;
  localparam int SCR_W     = 23;
  localparam int BI_W      = 20;

  localparam logic [1:0] KIND_DATA  = 2'd0;
  localparam logic [1:0] KIND_RAW   = 2'd1;
  localparam logic [1:0] KIND_CLEAR = 2'd2;

  localparam logic REG_CARRIER_STEP = 1'b0;
  localparam logic REG_AMPLITUDE    = 1'b1;

  localparam logic [9:0]  CARRIER_STEP_RST = 10'd72;
  localparam logic [15:0] AMPLITUDE_RST    = 16'd6554;

  typedef struct packed {
    logic [1:0] kind;
    logic       data_bit;
    logic [2:0] symbol;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       last;
    logic                       clipped;
  } out_item_t;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } ctrl_state_t;

  typedef struct packed {
    logic       load_bit;
    logic       load_sym;
    logic       clear;
    logic       issue;
    logic       last;
    logic [3:0] k;
  } dp_cmd_t;

  typedef struct packed {
    logic group_done;
    logic adv;
  } dp_sts_t;

  localparam logic [2:0] STEP_OF_TRIBIT [8] = '{3'd1, 3'd6, 3'd2, 3'd5, 3'd0, 3'd7, 3'd3, 3'd4};

  localparam logic signed [2:0] POINT_I [8] = '{3, 1, 0, -1, -3, -1, 0, 1};
  localparam logic signed [2:0] POINT_Q [8] = '{0, 1, 3, 1, 0, -1, -3, -1};

  localparam logic signed [16:0] PULSE_TAP [21] = '{
    32768, 32156, 30369, 27541, 23885, 19668, 15184, 10731, 6578, 2949,
    0, -2183, -3588, -4271, -4338, -3934, -3215, -2340, -1446, -642, 0
  };

  // History slot: zero means empty, n means element n-1
  function automatic logic signed [2:0] hist_i(input logic [3:0] h);
    logic [2:0] e;
    e = 3'(h - 4'd1);
    return (h == 4'd0) ? 3'sd0 : POINT_I[e];
  endfunction

  function automatic logic signed [2:0] hist_q(input logic [3:0] h);
    logic [2:0] e;
    e = 3'(h - 4'd1);
    return (h == 4'd0) ? 3'sd0 : POINT_Q[e];
  endfunction

endpackage

/* hdl/v29tx_ctrl.sv */
// Sequencer of the V.29 transmitter: accepts items, issues ten sample slots per symbol.
// Depends on v29tx_pkg.
module v29tx_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  v29tx_pkg::in_item_t in_data,
  output logic              in_ready,
  input  v29tx_pkg::dp_sts_t sts,
  output v29tx_pkg::dp_cmd_t cmd
);
  import v29tx_pkg::*;

  ctrl_state_t state_r, state_nxt;
  logic [3:0]  k_r, k_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      k_r     <= '0;
    end else begin
      state_r <= state_nxt;
      k_r     <= k_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    k_nxt     = k_r;
    in_ready  = 1'b0;
    cmd       = '0;
    cmd.k     = k_r;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          case (in_data.kind)
            KIND_DATA: begin
              cmd.load_bit = 1'b1;
              if (sts.group_done) begin
                state_nxt = ST_RUN;
                k_nxt     = '0;
              end
            end
            KIND_RAW: begin
              cmd.load_sym = 1'b1;
              state_nxt    = ST_RUN;
              k_nxt        = '0;
            end
            KIND_CLEAR: cmd.clear = 1'b1;
            default: ;
          endcase
        end
      end
      ST_RUN: begin
        if (sts.adv) begin
          cmd.issue = 1'b1;
          if (k_r == 4'(SPS - 1)) begin
            cmd.last  = 1'b1;
            state_nxt = ST_IDLE;
          end else begin
            k_nxt = k_r + 4'd1;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

/* hdl/v29tx_dp.sv */
// Datapath of the V.29 transmitter: scrambler, element and history, carrier ROM,
// four-stage sample pipeline with output register. Depends on v29tx_pkg.
module v29tx_dp #(
  parameter int SINE_TABLE_LENGTH = 1024
) (
  input  logic               clk,
  input  logic               rst_n,
  input  v29tx_pkg::in_item_t in_data,
  input  v29tx_pkg::dp_cmd_t cmd,
  output v29tx_pkg::dp_sts_t sts,
  input  logic               cfg_we,
  input  logic               cfg_addr,
  input  logic [15:0]        cfg_wdata,
  output logic               out_valid,
  input  logic               out_ready,
  output v29tx_pkg::out_item_t out_data
);
  import v29tx_pkg::*;

  localparam int PW      = $clog2(SINE_TABLE_LENGTH);
  localparam int QUARTER = SINE_TABLE_LENGTH / 4;
  localparam longint TWO_PI_Q30 = 64'sd6746518852;
  localparam longint Q30_ONE    = 64'sd1073741824;
  localparam int SH      = 47 - SAMPLE_W;
  localparam int ACC_W   = 2 * BI_W - 3;  // 37
  localparam int V_W     = 56;

  typedef logic signed [15:0] rom_t [SINE_TABLE_LENGTH];

  // Evaluated at elaboration only, to fill the carrier ROM
  function automatic longint sine_q15(input int p);
    int     q, r;
    longint x, x2, t, s, v;
    q = p >> (PW - 2);
    r = p & (QUARTER - 1);
    if ((q & 1) == 1) r = QUARTER - r;
    x  = (longint'(r) * TWO_PI_Q30) >>> PW;
    x2 = (x * x) >>> 30;
    t  = Q30_ONE;
    t  = Q30_ONE - ((x2 * t) >>> 30) / 110;
    t  = Q30_ONE - ((x2 * t) >>> 30) / 72;
    t  = Q30_ONE - ((x2 * t) >>> 30) / 42;
    t  = Q30_ONE - ((x2 * t) >>> 30) / 20;
    t  = Q30_ONE - ((x2 * t) >>> 30) / 6;
    s = (x * t) >>> 30;
    v = (s * 32767 + (64'sd1 <<< 29)) >>> 30;
    return (q >= 2) ? -v : v;
  endfunction

  function automatic rom_t build_rom();
    rom_t tbl;
    for (int p = 0; p < SINE_TABLE_LENGTH; p++) tbl[p] = 16'(sine_q15(p));
    return tbl;
  endfunction

  localparam rom_t SIN_ROM = build_rom();

  // Configuration
  logic [9:0]  step_r;
  logic [15:0] amp_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= CARRIER_STEP_RST;
      amp_r  <= AMPLITUDE_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_CARRIER_STEP: step_r <= cfg_wdata[9:0];
        REG_AMPLITUDE:    amp_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Symbol state
  logic [SCR_W-1:0] scr_r;
  logic [1:0]       bits_r;
  logic [2:0]       elem_r;
  logic [3:0]       hist_r [3];
  logic [PW-1:0]    phase_r;
  logic             fb;
  logic [2:0]       tri_bits;

  assign fb       = in_data.data_bit ^ scr_r[5] ^ scr_r[0];
  assign tri_bits = {fb, scr_r[22], scr_r[21]};

  logic adv;
  assign adv            = !out_valid || out_ready;
  assign sts.adv        = adv;
  assign sts.group_done = (bits_r == 2'd2);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scr_r   <= '0;
      bits_r  <= '0;
      elem_r  <= '0;
      hist_r  <= '{default: '0};
      phase_r <= '0;
    end else begin
      if (cmd.load_bit) begin
        scr_r <= {fb, scr_r[SCR_W-1:1]};
        if (bits_r == 2'd2) begin
          bits_r <= '0;
          elem_r <= elem_r + STEP_OF_TRIBIT[tri_bits];
        end else begin
          bits_r <= bits_r + 2'd1;
        end
      end
      if (cmd.load_sym) elem_r <= in_data.symbol;
      if (cmd.clear) begin
        scr_r  <= '0;
        bits_r <= '0;
      end
      if (cmd.issue) begin
        phase_r <= phase_r + PW'(step_r);
        if (cmd.last) begin
          hist_r[2] <= hist_r[1];
          hist_r[1] <= hist_r[0];
          hist_r[0] <= {1'b0, elem_r} + 4'd1;
        end
      end
    end
  end

  // Stage 0: baseband pulse sums and carrier lookup
  logic [4:0] ta, tb, tc, td;
  logic signed [BI_W-1:0] bi_c, bq_c;
  logic [PW-1:0] cos_addr;

  assign ta       = 5'(SPS) + 5'(cmd.k);
  assign tb       = 5'(cmd.k);
  assign tc       = 5'(SPS) - 5'(cmd.k);
  assign td       = 5'(2 * SPS) - 5'(cmd.k);
  assign cos_addr = phase_r + PW'(QUARTER);

  always_comb begin
    bi_c = BI_W'(PULSE_TAP[ta] * hist_i(hist_r[2]))
         + BI_W'(PULSE_TAP[tb] * hist_i(hist_r[1]))
         + BI_W'(PULSE_TAP[tc] * hist_i(hist_r[0]))
         + BI_W'(PULSE_TAP[td] * POINT_I[elem_r]);
    bq_c = BI_W'(PULSE_TAP[ta] * hist_q(hist_r[2]))
         + BI_W'(PULSE_TAP[tb] * hist_q(hist_r[1]))
         + BI_W'(PULSE_TAP[tc] * hist_q(hist_r[0]))
         + BI_W'(PULSE_TAP[td] * POINT_Q[elem_r]);
  end

  logic                    v0_r, v1_r, v2_r, v3_r;
  logic                    l0_r, l1_r, l2_r;
  logic signed [15:0]      sin_r, cos_r;
  logic signed [BI_W-1:0]  bi_r, bq_r;
  logic signed [ACC_W-1:0] acc_r;
  logic signed [ACC_W+8:0] ph_r, pl_r;
  out_item_t               out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (adv) begin
      v0_r <= cmd.issue;
      v1_r <= v0_r;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  logic signed [V_W-1:0] v_c, t_c;
  logic signed [V_W-SH-1:0] r_c;
  localparam logic signed [V_W-SH-1:0] MAXV = (V_W-SH)'((1 << (SAMPLE_W - 1)) - 1);
  localparam logic signed [V_W-SH-1:0] MINV = -(V_W-SH)'(1 << (SAMPLE_W - 1));

  always_comb begin
    v_c = (V_W'(ph_r) <<< 8) + V_W'(pl_r);
    t_c = v_c + (V_W'(1) <<< (SH - 1));
    r_c = (V_W-SH)'(t_c >>> SH);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sin_r <= SIN_ROM[phase_r];
      cos_r <= SIN_ROM[cos_addr];
      bi_r  <= bi_c;
      bq_r  <= bq_c;
      l0_r  <= cmd.last;
      acc_r <= ACC_W'(bi_r * sin_r) + ACC_W'(bq_r * cos_r);
      l1_r  <= l0_r;
      ph_r  <= acc_r * $signed({1'b0, amp_r[15:8]});
      pl_r  <= acc_r * $signed({1'b0, amp_r[7:0]});
      l2_r  <= l1_r;
      out_r.last <= l2_r;
      if (r_c > MAXV) begin
        out_r.sample  <= SAMPLE_W'(MAXV);
        out_r.clipped <= 1'b1;
      end else if (r_c < MINV) begin
        out_r.sample  <= SAMPLE_W'(MINV);
        out_r.clipped <= 1'b1;
      end else begin
        out_r.sample  <= SAMPLE_W'(r_c);
        out_r.clipped <= 1'b0;
      end
    end
  end

  assign out_valid = v3_r;
  assign out_data  = out_r;

endmodule

/* hdl/v29_psk_modulator_tx_core.sv */
// Top level of the V.29-style 8-phase DPSK transmitter (4800 bit/s flavor).
// Depends on v29tx_pkg, v29tx_ctrl and v29tx_dp.
//
// Usage:
//  - Input channel (in_valid/in_ready/in_data): one transfer per item. A data
//    item (kind 0) feeds one bit through the 1+x^-18+x^-23 scrambler; every
//    third bit forms a tribit and a symbol. A raw item (kind 1) sends the given
//    element. A clear item (kind 2) zeroes the scrambler and bit count. Kind 3
//    is dropped.
//  - Output channel (out_valid/out_ready/out_data): each symbol yields ten
//    sample transfers; last marks the tenth, clipped marks saturation.
//  - Config port: cfg_we with cfg_addr 0 writes carrier_step, 1 writes
//    amplitude_scale; write only while the block is idle.
// Timing: a symbol item is accepted, then issues ten sample slots, one slot per
// cycle while the receiver does not stall the output; no new item is accepted
// until the last slot is issued. Bit items that do not close a tribit, clear
// items and dropped items are accepted and leave the sequencer idle. Sample
// pipeline stages: carrier ROM read, mixer multiply, gain multiply, round/saturate.
// Reset (synchronous, rst_n low) clears scrambler, history, carrier phase and
// loads the default registers. When the receiver stalls, the whole sample
// pipeline holds; the output register keeps its transfer stable.
module v29_psk_modulator_tx_core #(
  parameter int SINE_TABLE_LENGTH = 1024
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  v29tx_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output v29tx_pkg::out_item_t out_data,
  input  logic                 cfg_we,
  input  logic                 cfg_addr,
  input  logic [15:0]          cfg_wdata
);
  import v29tx_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  // Sequencer: accept, then issue sample slots
  v29tx_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_data  (in_data),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Datapath: symbol state, carrier and sample pipeline
  v29tx_dp #(
    .SINE_TABLE_LENGTH (SINE_TABLE_LENGTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
